// ----- rtl/cad_pkg.sv -----
// Package for the address decoder: widths, status codes, base32 map and checksum step.
// No dependencies.
package cad_pkg;
	localparam int MaxPayload = 112;
	localparam int MinPayload = 14;
	localparam int MaxPrefix  = 16;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_MIXED    = 3'd1,
		ST_PREFIX   = 3'd2,
		ST_LENGTH   = 3'd3,
		ST_BADCHAR  = 3'd4,
		ST_CHECKSUM = 3'd5,
		ST_PADDING  = 3'd6,
		ST_VERSION  = 3'd7
	} status_t;

	localparam logic [1:0] REG_PFX_LOW  = 2'd0;
	localparam logic [1:0] REG_PFX_HIGH = 2'd1;
	localparam logic [1:0] REG_PFX_LEN  = 2'd2;

	// finished address handed from front to back
	typedef struct packed {
		logic [2:0]   status;
		logic         script;
		logic [159:0] hash;
	} job_t;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		to_lower = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
	endfunction

	// base32 lookup on a lowercased character; bit 5 set when invalid
	function automatic logic [5:0] b32_lookup(input logic [7:0] c);
		case (c)
			"q": b32_lookup = 6'd0;  "p": b32_lookup = 6'd1;
			"z": b32_lookup = 6'd2;  "r": b32_lookup = 6'd3;
			"y": b32_lookup = 6'd4;  "9": b32_lookup = 6'd5;
			"x": b32_lookup = 6'd6;  "8": b32_lookup = 6'd7;
			"g": b32_lookup = 6'd8;  "f": b32_lookup = 6'd9;
			"2": b32_lookup = 6'd10; "t": b32_lookup = 6'd11;
			"v": b32_lookup = 6'd12; "d": b32_lookup = 6'd13;
			"w": b32_lookup = 6'd14; "0": b32_lookup = 6'd15;
			"s": b32_lookup = 6'd16; "3": b32_lookup = 6'd17;
			"j": b32_lookup = 6'd18; "n": b32_lookup = 6'd19;
			"5": b32_lookup = 6'd20; "4": b32_lookup = 6'd21;
			"k": b32_lookup = 6'd22; "h": b32_lookup = 6'd23;
			"c": b32_lookup = 6'd24; "e": b32_lookup = 6'd25;
			"6": b32_lookup = 6'd26; "m": b32_lookup = 6'd27;
			"u": b32_lookup = 6'd28; "a": b32_lookup = 6'd29;
			"7": b32_lookup = 6'd30; "l": b32_lookup = 6'd31;
			default: b32_lookup = 6'd32;
		endcase
	endfunction

	function automatic logic [39:0] bch_step(input logic [39:0] c, input logic [4:0] v);
		logic [4:0]  top;
		logic [39:0] r;
		top = c[39:35];
		r = {c[34:0], v};
		if (top[0]) r = r ^ 40'h98f2bc8e61;
		if (top[1]) r = r ^ 40'h79b76d99e2;
		if (top[2]) r = r ^ 40'hf33e5fb3c4;
		if (top[3]) r = r ^ 40'hae2eabe2a8;
		if (top[4]) r = r ^ 40'h1e4f43e470;
		bch_step = r;
	endfunction
endpackage

// ----- rtl/cad_if.sv -----
// Valid/ready channel interfaces: address characters in, result items out.
// No dependencies; payload widths follow the fields of each item.
interface cad_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] address_char;
	logic       end_of_address;
	modport source (output valid, address_char, end_of_address, input ready);
	modport sink (input valid, address_char, end_of_address, output ready);
endinterface

interface cad_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic       script_hash_flag;
	logic [7:0] hash_byte;
	logic [4:0] byte_index;
	logic       final_result;
	modport source (output valid, status, script_hash_flag, hash_byte, byte_index,
		final_result, input ready);
	modport sink (input valid, status, script_hash_flag, hash_byte, byte_index,
		final_result, output ready);
endinterface

// ----- rtl/cad_front.sv -----
// Front part: per-character parse, checksum, delay line and bit packer.
// Depends on cad_pkg. Emits one job per address.
module cad_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  logic [7:0]          ch,
	input  logic                last,
	input  logic [63:0]         pfx_low,
	input  logic [63:0]         pfx_high,
	input  logic [4:0]          plen,
	input  logic [39:0]         seed,
	output logic                job_valid,
	output cad_pkg::job_t       job
);
	logic [39:0]  chk_q;
	logic [4:0]   dly_q [8];
	logic [11:0]  acc_q;
	logic [2:0]   pend_q;
	logic [4:0]   bcnt_q;
	logic [167:0] bytes_q;
	logic [7:0]   ccnt_q;
	logic         low_q, up_q, sep_q, mis_q, bad_q, nul_q;

	logic [7:0]   lc, pb;
	logic [5:0]   lk;
	logic [4:0]   v;
	logic [39:0]  chk_n;
	logic [11:0]  acc_n;
	logic [3:0]   pend_sum;
	logic [2:0]   pend_n;
	logic [4:0]   bcnt_n;
	logic [167:0] bytes_n;
	logic [7:0]   ccnt_n, nb;
	logic         is_sep, low_n, up_n, mis_n, bad_n, nul_n, sep_n;
	logic [2:0]   st;
	logic [7:0]   ver;
	logic [11:0]  padmask;

	always_comb begin
		lc = cad_pkg::to_lower(ch);
		pb = cad_pkg::to_lower(ccnt_q[3] ? pfx_high[{ccnt_q[2:0], 3'b000} +: 8]
			: pfx_low[{ccnt_q[2:0], 3'b000} +: 8]);
		lk = cad_pkg::b32_lookup(lc);
		v = lk[5] ? 5'd0 : lk[4:0];
		is_sep = !sep_q && ch == 8'h3a;
		low_n = low_q | (ch >= 8'h61 && ch <= 8'h7a);
		up_n  = up_q | (ch >= 8'h41 && ch <= 8'h5a);
		nul_n = nul_q | (ch == 8'd0);
		sep_n = sep_q | is_sep;
		mis_n = mis_q; bad_n = bad_q;
		chk_n = chk_q; acc_n = acc_q; pend_n = pend_q; bcnt_n = bcnt_q;
		bytes_n = bytes_q; ccnt_n = ccnt_q;
		pend_sum = {1'b0, pend_q} + 4'd5; nb = 8'd0;
		if (is_sep) begin
			if (ccnt_q != {3'b000, plen}) mis_n = 1'b1;
			bad_n = 1'b0;
			chk_n = 40'd1; acc_n = '0; pend_n = '0; bcnt_n = '0; ccnt_n = '0;
		end else begin
			if (!sep_q && (ccnt_q >= {3'b000, plen} || lc != pb)) mis_n = 1'b1;
			if (lk[5]) bad_n = 1'b1;
			chk_n = cad_pkg::bch_step((ccnt_q == 8'd0) ? seed : chk_q, v);
			if (ccnt_q >= 8'd8) begin
				acc_n = {acc_q[6:0], dly_q[ccnt_q[2:0]]};
				if (pend_sum >= 4'd8) begin
					pend_n = 3'(pend_sum - 4'd8);
					nb = 8'(acc_n >> pend_n);
					if (bcnt_q < 5'd21) bytes_n[{bcnt_q, 3'b000} +: 8] = nb;
					if (bcnt_q < 5'd31) bcnt_n = bcnt_q + 5'd1;
				end else begin
					pend_n = pend_sum[2:0];
				end
			end
			if (ccnt_q != 8'd255) ccnt_n = ccnt_q + 8'd1;
		end
		ver = bytes_n[7:0];
		padmask = (12'd1 << pend_n) - 12'd1;
		if (low_n && up_n) st = cad_pkg::ST_MIXED;
		else if (plen == 5'd0 || (sep_n && mis_n)) st = cad_pkg::ST_PREFIX;
		else if (ccnt_n < 8'(cad_pkg::MinPayload) || ccnt_n > 8'(cad_pkg::MaxPayload))
			st = cad_pkg::ST_LENGTH;
		else if (bad_n || nul_n) st = cad_pkg::ST_BADCHAR;
		else if (chk_n != 40'd1) st = cad_pkg::ST_CHECKSUM;
		else if (ccnt_n < 8'd10) st = cad_pkg::ST_LENGTH;
		else if (pend_n >= 3'd5 || (acc_n & padmask) != 12'd0) st = cad_pkg::ST_PADDING;
		else if (bcnt_n != 5'd21) st = cad_pkg::ST_LENGTH;
		else if (ver[7] || ver[6:3] > 4'd1 || ver[2:0] != 3'd0) st = cad_pkg::ST_VERSION;
		else st = cad_pkg::ST_OK;
		job.status = st;
		job.script = ver[3];
		job.hash = bytes_n[167:8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_q <= 40'd1; acc_q <= '0; pend_q <= '0; bcnt_q <= '0; ccnt_q <= '0;
			{low_q, up_q, sep_q, mis_q, bad_q, nul_q} <= '0;
			job_valid <= 1'b0;
		end else begin
			job_valid <= 1'b0;
			if (in_fire) begin
				if (last) begin
					job_valid <= 1'b1;
					chk_q <= 40'd1; acc_q <= '0; pend_q <= '0; bcnt_q <= '0; ccnt_q <= '0;
					{low_q, up_q, sep_q, mis_q, bad_q, nul_q} <= '0;
				end else begin
					chk_q <= chk_n; acc_q <= acc_n; pend_q <= pend_n; bcnt_q <= bcnt_n;
					ccnt_q <= ccnt_n;
					{low_q, up_q, sep_q, mis_q, bad_q, nul_q} <=
						{low_n, up_n, sep_n, mis_n, bad_n, nul_n};
				end
			end
		end
	end

	// payload stores
	always_ff @(posedge clk) begin
		if (in_fire && !is_sep) dly_q[ccnt_q[2:0]] <= v;
		if (in_fire) bytes_q <= bytes_n;
	end

`ifndef SYNTHESIS
	a_seed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && last |=> job_valid) else $error("job lost");
	a_cnt_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && last |=> ccnt_q == 8'd0) else $error("count not cleared");
	a_pend: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd7 && bcnt_q <= 5'd31) else $error("packer range");
`endif
endmodule

// ----- rtl/cad_back.sv -----
// Back part: two-entry job queue and result sequencer emitting bytes.
// Depends on cad_pkg and cad_res_if.
module cad_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_we,
	input  cad_pkg::job_t job_in,
	output logic          space,
	cad_res_if.source     res
);
	cad_pkg::job_t q_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	logic [4:0]    idx_q;
	logic          pop;
	cad_pkg::job_t h;

	assign h = q_q[rp_q];
	// one slot must stay free for the job of an item already in flight
	assign space = (cnt_q == 2'd0) || (cnt_q == 2'd1 && !job_we);
	assign res.valid = cnt_q != 2'd0;
	assign res.status = h.status;
	assign res.script_hash_flag = (h.status == cad_pkg::ST_OK) ? h.script : 1'b0;
	assign res.hash_byte = (h.status == cad_pkg::ST_OK) ? h.hash[{idx_q, 3'b000} +: 8] : 8'd0;
	assign res.byte_index = idx_q;
	assign res.final_result = (h.status != cad_pkg::ST_OK) || idx_q == 5'd19;
	assign pop = res.valid && res.ready && res.final_result;

	always_ff @(posedge clk) begin
		if (job_we) q_q[wp_q] <= job_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0; idx_q <= '0;
		end else begin
			if (job_we) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, job_we} - {1'b0, pop};
			if (res.valid && res.ready) idx_q <= res.final_result ? 5'd0 : idx_q + 5'd1;
		end
	end

`ifndef SYNTHESIS
	a_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !job_we || pop) else $error("queue overflow");
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= 5'd19) else $error("index range");
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && h.status != cad_pkg::ST_OK |-> idx_q == 5'd0) else $error("error item late");
`endif
endmodule

// ----- rtl/cad_seed.sv -----
// Configuration registers and prefix checksum seed, one symbol per cycle unless a write restarts it.
// Depends on cad_pkg.
module cad_seed (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [63:0] cfg_data,
	output logic [63:0] pfx_low,
	output logic [63:0] pfx_high,
	output logic [4:0]  plen,
	output logic [39:0] seed,
	output logic        busy
);
	logic [4:0]  raw_q, pos_q;
	logic [39:0] c_q;
	logic [4:0]  n;
	logic [7:0]  b;

	assign n = (raw_q > 5'(cad_pkg::MaxPrefix)) ? 5'(cad_pkg::MaxPrefix) : raw_q;
	assign plen = n;
	assign b = cad_pkg::to_lower(pos_q[3] ? pfx_high[{pos_q[2:0], 3'b000} +: 8]
		: pfx_low[{pos_q[2:0], 3'b000} +: 8]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pfx_low <= '0; pfx_high <= '0; raw_q <= 5'd1;
			pos_q <= '0; c_q <= 40'd1; busy <= 1'b1; seed <= '0;
		end else if (cfg_we && cfg_idx != 2'd3) begin
			case (cfg_idx)
				cad_pkg::REG_PFX_LOW:  pfx_low <= cfg_data;
				cad_pkg::REG_PFX_HIGH: pfx_high <= cfg_data;
				cad_pkg::REG_PFX_LEN:  raw_q <= cfg_data[4:0];
				default: ;
			endcase
			pos_q <= '0; c_q <= 40'd1; busy <= 1'b1;
		end else if (busy) begin
			if (pos_q < n) begin
				c_q <= cad_pkg::bch_step(c_q, b[4:0]);
				pos_q <= pos_q + 5'd1;
			end else begin
				seed <= cad_pkg::bch_step(c_q, 5'd0);
				busy <= 1'b0;
			end
		end
	end
endmodule

// ----- rtl/cashaddr_address_decoder_top.sv -----
// Top level of the address decoder: seed unit, front parser and back sequencer.
// Depends on cad_pkg, cad_if, cad_seed, cad_front, cad_back.
//
//  channel | dir | payload                                   | accepted
//  chars   | in  | address_char, end_of_address              | valid && ready
//  results | out | status, script_hash_flag, hash_byte,      | valid && ready
//          |     | byte_index, final_result                  |
//  cfg     | in  | cfg_we, cfg_index, cfg_data               | cfg_we high
//
// One character a cycle while chars.ready is high; the final character produces a job the next cycle,
// which the back part plays out as 20 result items (or one error item).
// A two-job queue lets the front parse the next address while results stall.
// After reset and after any write to a prefix register the prefix seed is rebuilt,
// one prefix symbol a cycle unless a write restarts it; no item is taken meanwhile.
module cashaddr_address_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	cad_char_if.sink    chars,
	cad_res_if.source   results
);
	logic [63:0]   pfx_low, pfx_high;
	logic [4:0]    plen;
	logic [39:0]   seed;
	logic          busy, space, job_valid, in_fire;
	cad_pkg::job_t job;

	cad_seed u_seed (.clk, .arst_n, .cfg_we, .cfg_idx(cfg_index), .cfg_data,
		.pfx_low, .pfx_high, .plen, .seed, .busy);

	assign chars.ready = !busy && space;
	assign in_fire = chars.valid && chars.ready;

	cad_front u_front (.clk, .arst_n, .in_fire, .ch(chars.address_char),
		.last(chars.end_of_address), .pfx_low, .pfx_high, .plen, .seed,
		.job_valid, .job);

	// job of the final character is registered here, alongside job_valid
	cad_pkg::job_t job_s1;
	always_ff @(posedge clk) begin
		if (in_fire && chars.end_of_address) job_s1 <= job;
	end

	cad_back u_back (.clk, .arst_n, .job_we(job_valid), .job_in(job_s1), .space,
		.res(results));
endmodule
